// ===== hdl/shrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow-ray primitive test package
// Shared types, codes and helpers for the shadow-ray primitive test pipeline.
// ----------------------------------------------------------------------------
package shrp_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Object kind codes carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_SPHERE = 2'd0,
    KIND_CYL    = 2'd1,
    KIND_CONE   = 2'd2,
    KIND_PLANE  = 2'd3
  } kind_t;

  // Control bits that travel down the pipeline with each item.
  typedef struct packed {
    logic vld;
    logic eor;
    logic plane;
    logic ok;
  } ctl_t;

  // Magnitude of a 33-bit signed operand, clamped to 2^32 - 1.
  function automatic logic [31:0] clamp_mag(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return m[32] ? 32'hFFFF_FFFF : m[31:0];
  endfunction

endpackage

// ===== hdl/shadow_ray_primitive_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow-ray primitive test
// Tests one shadow ray against one sphere, z cylinder, z cone or plane and
// returns the hit parameter t in fixed point.
// ----------------------------------------------------------------------------
// The block takes one ray/object pair per clock while the output is not held
// and returns one result per pair, in order, through a chain of register
// stages: six stages of operand setup, products and coefficient sums, a
// 32-stage one-bit-per-stage square root, one numerator stage, a
// (34 + FRAC_BITS)-stage one-bit-per-stage divider and the output register.
// The whole pipeline holds while a result waits at the output and advances in
// every other cycle, so a new item is taken in every cycle the output is free
// or being taken.
module shadow_ray_primitive_test #(
  parameter int FRAC_BITS = shrp_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, obj_x, obj_y, obj_z,
  // obj_param (32 bits each, lowest first)
  input  logic [319:0] in_tdata,
  // obj_kind
  input  logic [1:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit_distance
  output logic [31:0]  out_tdata,
  // has_root (bit 0), blocks_light (bit 1)
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  localparam int PW  = 65 - FRAC_BITS;
  localparam int SW  = PW + 2;
  localparam int NSQ = 32;
  localparam int NW  = 34 + FRAC_BITS;

  localparam logic signed [31:0] ONE_RAW = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [31:0] EPS_RAW = 32'((64'd1 << FRAC_BITS) / 100000);
  localparam logic signed [31:0] NO_HIT  = -ONE_RAW;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [SW-1:0] CMAX  = SW'(64'sh7FFF_FFFF);

  // Fixed-point product: clamped magnitudes, truncated toward zero.
  function automatic logic signed [PW-1:0] fxm(input logic signed [32:0] x,
                                                input logic signed [32:0] y);
    logic [63:0] pr;
    logic [63:0] sh;
    logic signed [PW-1:0] m;
    pr = 64'(shrp_pkg::clamp_mag(x)) * 64'(shrp_pkg::clamp_mag(y));
    sh = pr >> FRAC_BITS;
    m  = $signed({1'b0, sh[PW-2:0]});
    return (x[32] ^ y[32]) ? -m : m;
  endfunction

  // Symmetric saturation of a sum to +-(2^31 - 1).
  function automatic logic signed [31:0] sat_s(input logic signed [SW-1:0] v);
    if (v > CMAX) begin
      return S32_MAX;
    end else if (v < -CMAX) begin
      return -S32_MAX;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [SW-1:0] sx(input logic signed [PW-1:0] v);
    return {{(SW-PW){v[PW-1]}}, v};
  endfunction

  logic adv;
  logic out_tvalid_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: offsets and multiplier operand selection.
  // --------------------------------------------------------------------------
  logic signed [31:0] ox, oy, oz, dx, dy, dz, cx, cy, cz, pp;
  logic signed [32:0] ex, ey, ez;
  shrp_pkg::kind_t    kind_in;
  logic               plane_in;
  logic signed [32:0] opa_nxt [0:9];
  logic signed [32:0] opb_nxt [0:9];
  shrp_pkg::ctl_t     ctl1_nxt;

  assign ox = $signed(in_tdata[31:0]);
  assign oy = $signed(in_tdata[63:32]);
  assign oz = $signed(in_tdata[95:64]);
  assign dx = $signed(in_tdata[127:96]);
  assign dy = $signed(in_tdata[159:128]);
  assign dz = $signed(in_tdata[191:160]);
  assign cx = $signed(in_tdata[223:192]);
  assign cy = $signed(in_tdata[255:224]);
  assign cz = $signed(in_tdata[287:256]);
  assign pp = $signed(in_tdata[319:288]);
  assign kind_in  = shrp_pkg::kind_t'(in_tuser);
  assign plane_in = (kind_in == shrp_pkg::KIND_PLANE);
  assign ex = {ox[31], ox} - {cx[31], cx};
  assign ey = {oy[31], oy} - {cy[31], cy};
  assign ez = {oz[31], oz} - {cz[31], cz};

  always_comb begin
    // A plane uses the first six multipliers for O.N and N.D.
    opa_nxt[0] = plane_in ? {ox[31], ox} : {dx[31], dx};
    opb_nxt[0] = plane_in ? {cx[31], cx} : {dx[31], dx};
    opa_nxt[1] = plane_in ? {oy[31], oy} : {dy[31], dy};
    opb_nxt[1] = plane_in ? {cy[31], cy} : {dy[31], dy};
    opa_nxt[2] = plane_in ? {oz[31], oz} : {dz[31], dz};
    opb_nxt[2] = plane_in ? {cz[31], cz} : {dz[31], dz};
    opa_nxt[3] = plane_in ? {cx[31], cx} : {dx[31], dx};
    opb_nxt[3] = plane_in ? {dx[31], dx} : ex;
    opa_nxt[4] = plane_in ? {cy[31], cy} : {dy[31], dy};
    opb_nxt[4] = plane_in ? {dy[31], dy} : ey;
    opa_nxt[5] = plane_in ? {cz[31], cz} : {dz[31], dz};
    opb_nxt[5] = plane_in ? {dz[31], dz} : ez;
    opa_nxt[6] = ex;
    opb_nxt[6] = ex;
    opa_nxt[7] = ey;
    opb_nxt[7] = ey;
    opa_nxt[8] = ez;
    opb_nxt[8] = ez;
    opa_nxt[9] = {pp[31], pp};
    opb_nxt[9] = {pp[31], pp};
    ctl1_nxt.vld   = in_tvalid;
    ctl1_nxt.eor   = in_tlast;
    ctl1_nxt.plane = plane_in;
    ctl1_nxt.ok    = (dx != '0) || (dy != '0) || (dz != '0);
  end

  logic signed [32:0] opa1_r [0:9];
  logic signed [32:0] opb1_r [0:9];
  shrp_pkg::kind_t    kind1_r;
  logic signed [31:0] p1_r;
  shrp_pkg::ctl_t     ctl1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (adv) begin
      ctl1_r <= ctl1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 10; i++) begin
        opa1_r[i] <= opa_nxt[i];
        opb1_r[i] <= opb_nxt[i];
      end
      kind1_r <= kind_in;
      p1_r    <= pp;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: ten fixed-point products.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] prod2_r [0:9];
  shrp_pkg::kind_t      kind2_r;
  logic signed [31:0]   p2_r;
  shrp_pkg::ctl_t       ctl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (adv) begin
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 10; i++) begin
        prod2_r[i] <= fxm(opa1_r[i], opb1_r[i]);
      end
      kind2_r <= kind1_r;
      p2_r    <= p1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: cone terms, tan squared times the saturated z products.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] prod3_r [0:9];
  logic signed [PW-1:0] kp3_r [0:2];
  shrp_pkg::kind_t      kind3_r;
  logic signed [31:0]   p3_r;
  shrp_pkg::ctl_t       ctl3_r;
  logic signed [31:0]   zs0, zs1, zs2;

  assign zs0 = sat_s(sx(prod2_r[2]));
  assign zs1 = sat_s(sx(prod2_r[5]));
  assign zs2 = sat_s(sx(prod2_r[8]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else if (adv) begin
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod3_r <= prod2_r;
      kp3_r[0] <= fxm({p2_r[31], p2_r}, {zs0[31], zs0});
      kp3_r[1] <= fxm({p2_r[31], p2_r}, {zs1[31], zs1});
      kp3_r[2] <= fxm({p2_r[31], p2_r}, {zs2[31], zs2});
      kind3_r <= kind2_r;
      p3_r    <= p2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: coefficient sums. For a plane, a holds N.D and h holds O.N + off.
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] asum, hsum, csum;
  logic signed [SW-1:0] e [0:9];

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      e[i] = sx(prod3_r[i]);
    end
    case (kind3_r)
      shrp_pkg::KIND_SPHERE: begin
        asum = e[0] + e[1] + e[2];
        hsum = e[3] + e[4] + e[5];
        csum = e[6] + e[7] + e[8] - e[9];
      end
      shrp_pkg::KIND_CYL: begin
        asum = e[0] + e[1];
        hsum = e[3] + e[4];
        csum = e[6] + e[7] - e[9];
      end
      shrp_pkg::KIND_CONE: begin
        asum = e[0] + e[1] - sx(kp3_r[0]);
        hsum = e[3] + e[4] - sx(kp3_r[1]);
        csum = e[6] + e[7] - sx(kp3_r[2]);
      end
      default: begin
        asum = e[3] + e[4] + e[5];
        hsum = e[0] + e[1] + e[2] + {{(SW-32){p3_r[31]}}, p3_r};
        csum = '0;
      end
    endcase
  end

  logic signed [31:0] a4_r, h4_r, c4_r;
  shrp_pkg::ctl_t     ctl4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
    end else if (adv) begin
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a4_r <= sat_s(asum);
      h4_r <= sat_s(hsum);
      c4_r <= sat_s(csum);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: discriminant products h*h and a*c.
  // --------------------------------------------------------------------------
  logic signed [63:0] hh5_r, ac5_r;
  logic signed [31:0] a5_r, h5_r;
  shrp_pkg::ctl_t     ctl5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r <= '0;
    end else if (adv) begin
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hh5_r <= 64'(h4_r) * 64'(h4_r);
      ac5_r <= 64'(a4_r) * 64'(c4_r);
      a5_r  <= a4_r;
      h5_r  <= h4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: discriminant and root existence, feeding the square root.
  // --------------------------------------------------------------------------
  logic signed [63:0] disc;
  logic               anz;
  shrp_pkg::ctl_t     ctl6_nxt;

  always_comb begin
    disc = hh5_r - ac5_r;
    anz  = (a5_r != '0);
    ctl6_nxt = ctl5_r;
    if (ctl5_r.plane) begin
      ctl6_nxt.ok = ctl5_r.ok && anz;
    end else begin
      ctl6_nxt.ok = anz && !disc[63];
    end
  end

  logic [32:0]        sq_rem_r  [0:NSQ];
  logic [31:0]        sq_root_r [0:NSQ];
  logic [63:0]        sq_rad_r  [0:NSQ];
  logic signed [31:0] sq_a_r    [0:NSQ];
  logic signed [31:0] sq_h_r    [0:NSQ];
  shrp_pkg::ctl_t     sq_ctl_r  [0:NSQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_ctl_r[0] <= '0;
    end else if (adv) begin
      sq_ctl_r[0] <= ctl6_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_rad_r[0]  <= (ctl5_r.plane || !ctl6_nxt.ok) ? 64'd0 : disc;
      sq_a_r[0]    <= a5_r;
      sq_h_r[0]    <= h5_r;
    end
  end

  // --------------------------------------------------------------------------
  // Square root: one result bit per stage, restoring digit recurrence.
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    logic [34:0] r2;
    logic [34:0] trial;
    logic        ge;

    assign r2    = {sq_rem_r[j], sq_rad_r[j][63:62]};
    assign trial = {1'b0, sq_root_r[j], 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_ctl_r[j+1] <= '0;
      end else if (adv) begin
        sq_ctl_r[j+1] <= sq_ctl_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[j+1]  <= ge ? 33'(r2 - trial) : r2[32:0];
        sq_root_r[j+1] <= {sq_root_r[j][30:0], ge};
        sq_rad_r[j+1]  <= {sq_rad_r[j][61:0], 2'b00};
        sq_a_r[j+1]    <= sq_a_r[j];
        sq_h_r[j+1]    <= sq_h_r[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Numerator stage: pick the smaller root, split into sign and magnitudes.
  // --------------------------------------------------------------------------
  logic signed [31:0] na, nh32;
  logic signed [33:0] nh, ns, nn;
  logic [33:0]        nmag;
  logic               nneg;
  logic [31:0]        dmag;

  always_comb begin
    na   = sq_a_r[NSQ];
    nh32 = sq_h_r[NSQ];
    nh   = -{{2{nh32[31]}}, nh32};
    ns   = $signed({2'b00, sq_root_r[NSQ]});
    if (sq_ctl_r[NSQ].plane) begin
      nn = nh;
    end else if (!na[31]) begin
      nn = nh - ns;
    end else begin
      nn = nh + ns;
    end
    nneg = nn[33] ^ na[31];
    nmag = nn[33] ? 34'(-nn) : 34'(nn);
    dmag = na[31] ? 32'(-na) : 32'(na);
  end

  logic [31:0]    dv_rem_r [0:NW];
  logic [NW-1:0]  dv_num_r [0:NW];
  logic [NW-1:0]  dv_q_r   [0:NW];
  logic [31:0]    dv_d_r   [0:NW];
  logic           dv_neg_r [0:NW];
  shrp_pkg::ctl_t dv_ctl_r [0:NW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ctl_r[0] <= '0;
    end else if (adv) begin
      dv_ctl_r[0] <= sq_ctl_r[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0] <= '0;
      dv_num_r[0] <= {nmag, {FRAC_BITS{1'b0}}};
      dv_q_r[0]   <= '0;
      dv_d_r[0]   <= dmag;
      dv_neg_r[0] <= nneg;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: one quotient bit per stage, restoring long division.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [32:0] r2;
    logic        ge;

    assign r2 = {dv_rem_r[k], dv_num_r[k][NW-1]};
    assign ge = (r2 >= {1'b0, dv_d_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_ctl_r[k+1] <= '0;
      end else if (adv) begin
        dv_ctl_r[k+1] <= dv_ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[k+1] <= ge ? 32'(r2 - {1'b0, dv_d_r[k]}) : r2[31:0];
        dv_num_r[k+1] <= {dv_num_r[k][NW-2:0], 1'b0};
        dv_q_r[k+1]   <= {dv_q_r[k][NW-2:0], ge};
        dv_d_r[k+1]   <= dv_d_r[k];
        dv_neg_r[k+1] <= dv_neg_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final stage: sign, saturation, no-root value and the light test.
  // --------------------------------------------------------------------------
  logic [NW-1:0]      qmag;
  logic               qneg;
  logic signed [31:0] tsat, tfin;
  logic               root;
  logic               blocks;

  always_comb begin
    qmag = dv_q_r[NW];
    qneg = dv_neg_r[NW];
    if (!qneg) begin
      tsat = (qmag > NW'(64'h7FFF_FFFF)) ? S32_MAX : $signed(qmag[31:0]);
    end else begin
      tsat = (qmag > NW'(64'h8000_0000)) ? S32_MIN : $signed(32'(-qmag[31:0]));
    end
    // A plane hit behind the origin is no root; a quadric root always counts.
    root   = dv_ctl_r[NW].ok && (!dv_ctl_r[NW].plane || !qneg || (qmag == '0));
    tfin   = root ? tsat : NO_HIT;
    blocks = root && (tfin > EPS_RAW) && (tfin < ONE_RAW);
  end

  logic [31:0] out_tdata_r;
  logic [1:0]  out_tuser_r;
  logic        out_tlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= dv_ctl_r[NW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= tfin;
      out_tuser_r <= {blocks, root};
      out_tlast_r <= dv_ctl_r[NW].eor;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

`ifndef NO_ASSERTIONS
  // A blocking result must also report a root.
  a_block_has_root : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("blocks_light without has_root");

  // A result without a root carries minus one.
  a_no_root_value : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == NO_HIT)
    else $error("no-root result with wrong hit distance");

  // Input is taken exactly when the output stage can move.
  a_ready_rule : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready out of step with output stage");

  // Reset leaves no result pending.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");
`endif

endmodule

// ===== tb/sv/shadow_ray_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow-ray primitive checker
// Watches both stream channels, predicts the hit result of every accepted
// ray/object transfer and compares each result transfer, in order.
// ----------------------------------------------------------------------------
module shadow_ray_checker #(
  parameter int FRAC_BITS = shrp_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [319:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending_hits
);

  typedef struct packed {
    logic [31:0] tval;
    logic        root;
    logic        blocks;
    logic        done;
  } hit_t;

  localparam longint ONE_RAW = longint'(1) << FRAC_BITS;
  localparam longint EPS_RAW = ONE_RAW / 100000;
  localparam longint S32_MAX = 64'sd2147483647;

  hit_t expected_hits[$];

  function automatic longint clip_coef(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < -S32_MAX) return -S32_MAX;
    return v;
  endfunction

  function automatic longint clip_out(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < -S32_MAX - 1) return -S32_MAX - 1;
    return v;
  endfunction

  // Fixed-point product: clamped magnitudes, truncated toward zero, then signed.
  function automatic longint fmul(longint x, longint y);
    logic [63:0] ux, uy, p;
    ux = x < 0 ? 64'(-x) : 64'(x);
    uy = y < 0 ? 64'(-y) : 64'(y);
    if (ux > 64'hFFFF_FFFF) ux = 64'hFFFF_FFFF;
    if (uy > 64'hFFFF_FFFF) uy = 64'hFFFF_FFFF;
    p = (ux * uy) >> FRAC_BITS;
    return ((x < 0) != (y < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Smaller root of a t^2 + 2 h t + c = 0, if any.
  function automatic logic smaller_root(longint a, longint h, longint c, output longint t);
    longint disc, s, k1, k2;
    t = -ONE_RAW;
    if (a == 0) return 1'b0;
    disc = h * h - a * c;
    if (disc < 0) return 1'b0;
    s = longint'(floor_sqrt(64'(disc)));
    k1 = ((-h - s) * ONE_RAW) / a;
    k2 = ((-h + s) * ONE_RAW) / a;
    t = clip_out(k1 < k2 ? k1 : k2);
    return 1'b1;
  endfunction

  function automatic hit_t predict_hit(logic [319:0] d, shrp_pkg::kind_t kind, logic eor);
    longint ox, oy, oz, dx, dy, dz, cx, cy, cz, p, ex, ey, ez;
    longint a, h, c, t, num, den, q;
    logic root;
    hit_t r;
    ox = longint'($signed(d[31:0]));    oy = longint'($signed(d[63:32]));
    oz = longint'($signed(d[95:64]));   dx = longint'($signed(d[127:96]));
    dy = longint'($signed(d[159:128])); dz = longint'($signed(d[191:160]));
    cx = longint'($signed(d[223:192])); cy = longint'($signed(d[255:224]));
    cz = longint'($signed(d[287:256])); p  = longint'($signed(d[319:288]));
    ex = ox - cx; ey = oy - cy; ez = oz - cz;
    t = -ONE_RAW;
    root = 1'b0;
    case (kind)
      shrp_pkg::KIND_SPHERE: begin
        a = clip_coef(fmul(dx, dx) + fmul(dy, dy) + fmul(dz, dz));
        h = clip_coef(fmul(dx, ex) + fmul(dy, ey) + fmul(dz, ez));
        c = clip_coef(fmul(ex, ex) + fmul(ey, ey) + fmul(ez, ez) - fmul(p, p));
        root = smaller_root(a, h, c, t);
      end
      shrp_pkg::KIND_CYL: begin
        a = clip_coef(fmul(dx, dx) + fmul(dy, dy));
        h = clip_coef(fmul(dx, ex) + fmul(dy, ey));
        c = clip_coef(fmul(ex, ex) + fmul(ey, ey) - fmul(p, p));
        root = smaller_root(a, h, c, t);
      end
      shrp_pkg::KIND_CONE: begin
        a = clip_coef(fmul(dx, dx) + fmul(dy, dy) - fmul(p, clip_coef(fmul(dz, dz))));
        h = clip_coef(fmul(dx, ex) + fmul(dy, ey) - fmul(p, clip_coef(fmul(dz, ez))));
        c = clip_coef(fmul(ex, ex) + fmul(ey, ey) - fmul(p, clip_coef(fmul(ez, ez))));
        root = smaller_root(a, h, c, t);
      end
      default: begin
        if (dx != 0 || dy != 0 || dz != 0) begin
          num = clip_coef(fmul(ox, cx) + fmul(oy, cy) + fmul(oz, cz) + p);
          den = clip_coef(fmul(cx, dx) + fmul(cy, dy) + fmul(cz, dz));
          if (den != 0) begin
            q = (-num * ONE_RAW) / den;
            if (q >= 0) begin
              t = clip_out(q);
              root = 1'b1;
            end
          end
        end
      end
    endcase
    if (!root) t = -ONE_RAW;
    r.tval = t[31:0];
    r.root = root;
    r.blocks = root && t > EPS_RAW && t < ONE_RAW;
    r.done = eor;
    return r;
  endfunction

  assign pending_hits = expected_hits.size();

  // Predict on every input transfer and check every result transfer.
  always @(posedge clk) begin
    hit_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_hits.push_back(predict_hit(in_tdata, shrp_pkg::kind_t'(in_tuser), in_tlast));
      if (out_tvalid && out_tready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result transfer tval=%h user=%b last=%b",
                   $time, out_tdata, out_tuser, out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_hits.pop_front();
          if (out_tdata !== want.tval || out_tuser !== {want.blocks, want.root} ||
              out_tlast !== want.done) begin
            $display("%0t: mismatch expected tval=%h blk=%b root=%b last=%b",
                     $time, want.tval, want.blocks, want.root, want.done);
            $display("%0t:          actual   tval=%h blk=%b root=%b last=%b",
                     $time, out_tdata, out_tuser[1], out_tuser[0], out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_shadow_ray_primitive_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow-ray primitive testbench
// Drives directed and random ray/object pairs with random idling on both
// channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_shadow_ray_primitive_test;

  localparam int FRAC_BITS = shrp_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 74 + FRAC_BITS;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [319:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  int           fail_count;
  int           pending_hits;

  int send_idle_pct = 19;
  int recv_idle_pct = 55;
  bit recv_hold = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  shadow_ray_primitive_test #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  shadow_ray_checker #(.FRAC_BITS(FRAC_BITS)) hit_checker (.*);

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one pair and wait for its transfer, with random gaps before it.
  task automatic send_pair(logic [31:0] o[3], logic [31:0] d[3], shrp_pkg::kind_t kind,
                           logic [31:0] obj[3], logic [31:0] prm, logic eor);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {prm, obj[2], obj[1], obj[0], d[2], d[1], d[0], o[2], o[1], o[0]};
    in_tuser  <= kind;
    in_tlast  <= eor;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
      default: return 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
    endcase
  endfunction

  // Random pair: mostly scenes of plausible size, some full-range noise.
  task automatic send_random(logic eor);
    logic [31:0] o[3], d[3], obj[3], prm;
    int mode;
    shrp_pkg::kind_t kind;
    mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(1) ? 1 : 2);
    kind = shrp_pkg::kind_t'($urandom_range(3));
    foreach (o[i]) o[i] = rand_coord(mode);
    foreach (d[i]) d[i] = $urandom_range(0, 15) == 0 ? 32'd0 : rand_coord(mode);
    foreach (obj[i]) obj[i] = rand_coord(mode);
    if (mode == 0) prm = $urandom();
    else if (kind == shrp_pkg::KIND_CONE) prm = $urandom_range(0, 2 * 65536);
    else prm = rand_coord(mode);
    if (kind == shrp_pkg::KIND_PLANE && $urandom_range(3) == 0) obj = '{0, 0, ONE};
    send_pair(o, d, kind, obj, prm, eor);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_hits != 0) @(posedge clk);
  endtask

  // Stimulus and verdict.
  initial begin
    logic [31:0] z3[3];
    int remaining;
    z3 = '{0, 0, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unit sphere hit, miss, tangent, each kind, degenerate cases.
    send_pair('{0, 0, 0}, '{0, 0, 4 * ONE}, shrp_pkg::KIND_SPHERE, '{0, 0, 2 * ONE}, ONE, 1'b0);
    send_pair('{0, 0, 0}, '{0, 0, 4 * ONE}, shrp_pkg::KIND_SPHERE, '{5 * ONE, 0, 2 * ONE}, ONE,
              1'b0);
    send_pair('{ONE, 0, 0}, '{0, 0, 4 * ONE}, shrp_pkg::KIND_SPHERE, '{0, 0, 2 * ONE}, ONE,
              1'b0);
    send_pair('{0, 0, 0}, z3, shrp_pkg::KIND_SPHERE, '{0, 0, 2 * ONE}, ONE, 1'b1);
    send_pair('{0, 0, 0}, '{4 * ONE, 0, ONE}, shrp_pkg::KIND_CYL, '{2 * ONE, 0, 0}, ONE, 1'b0);
    send_pair('{0, 0, 0}, '{0, 0, ONE}, shrp_pkg::KIND_CYL, '{2 * ONE, 0, 0}, ONE, 1'b0);
    send_pair('{ONE, 0, -ONE}, '{0, 0, ONE}, shrp_pkg::KIND_CONE, '{0, 0, 0}, ONE, 1'b0);
    send_pair('{-3 * ONE, 0, 2 * ONE}, '{6 * ONE, 0, 0}, shrp_pkg::KIND_CONE, '{0, 0, 0},
              ONE / 4, 1'b1);
    send_pair('{0, 0, 0}, '{0, 0, 4 * ONE}, shrp_pkg::KIND_PLANE, '{0, 0, ONE}, -2 * ONE, 1'b0);
    send_pair('{0, 0, 0}, '{4 * ONE, 0, 0}, shrp_pkg::KIND_PLANE, '{0, 0, ONE}, -2 * ONE, 1'b0);
    send_pair('{0, 0, 0}, z3, shrp_pkg::KIND_PLANE, '{0, 0, ONE}, -2 * ONE, 1'b0);
    send_pair('{0, 0, 0}, '{0, 0, ONE}, shrp_pkg::KIND_PLANE, '{0, 0, ONE}, 2 * ONE, 1'b0);
    send_pair('{0, 0, 0}, '{0, 0, ONE}, shrp_pkg::KIND_PLANE, '{0, 0, ONE}, 0, 1'b1);
    send_pair('{0, 0, 4 * ONE}, '{0, 0, ONE}, shrp_pkg::KIND_SPHERE, '{0, 0, 0}, ONE, 1'b0);
    send_pair('{0, 0, 0}, '{0, 0, 1}, shrp_pkg::KIND_SPHERE, '{0, 0, 2 * ONE}, ONE, 1'b0);
    send_pair('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
              '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, shrp_pkg::KIND_SPHERE,
              '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 32'h7FFF_FFFF, 1'b0);
    send_pair('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
              '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, shrp_pkg::KIND_CONE,
              '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 32'h8000_0000, 1'b1);
    send_pair('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
              '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, shrp_pkg::KIND_PLANE,
              '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 32'h8000_0000, 1'b0);
    send_pair('{0, 0, 0}, '{ONE, 0, 0}, shrp_pkg::KIND_CYL, '{0, 0, 0}, 32'h8000_0000, 1'b1);

    // Sender pauses until every result has come.
    wait_drained();

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      begin
        send_idle_pct = 0;
        repeat (150) send_random($urandom_range(3) == 0);
      end
    join
    wait_drained();

    // Random phases: receiver idles more, then sender more, then neither.
    send_idle_pct = 19; recv_idle_pct = 55;
    repeat (130) send_random($urandom_range(3) == 0);
    send_idle_pct = 55; recv_idle_pct = 19;
    repeat (130) send_random($urandom_range(3) == 0);
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (130) send_random($urandom_range(3) == 0);
    in_tvalid <= 1'b0;

    remaining = 200000;
    while (pending_hits != 0 && remaining > 0) begin
      @(posedge clk);
      remaining--;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0 && pending_hits == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
